@@ src/avp3_pkg.sv @@
// Shared types and fixed constants of the streaming 3D average pool.
// Used by the front end, the divider, the accumulate stage and the top level.
package avp3_pkg;

	// Configuration port shape
	localparam int CFG_IDX_W  = 3;
	localparam int CFG_DATA_W = 9;

	// Result tag widths: three window coordinates and a channel
	localparam int COORD_W = 8;
	localparam int CHAN_W  = 4;
	localparam int TAG_W   = 3 * COORD_W + CHAN_W;

	// Configuration register indexes
	typedef enum logic [CFG_IDX_W-1:0] {
		CFG_WINDOW_X = 3'd0,
		CFG_WINDOW_Y = 3'd1,
		CFG_WINDOW_Z = 3'd2,
		CFG_SIZE_X   = 3'd3,
		CFG_SIZE_Y   = 3'd4,
		CFG_SIZE_Z   = 3'd5,
		CFG_CHANNELS = 3'd6
	} cfg_reg_t;

	// Per-sample control flags carried from the front end to the back end
	typedef struct packed {
		logic first;  // first sample of its window: overwrite the sum
		logic done;   // last sample of its window: emit the mean
		logic last;   // final mean of the volume
	} avp3_ctl_t;

	localparam int CTL_W = $bits(avp3_ctl_t);

	typedef enum logic {
		FE_RUN,
		FE_SYNC
	} fe_state_t;

	typedef enum logic [1:0] {
		DV_IDLE,
		DV_RUN,
		DV_DONE
	} dv_state_t;

endpackage

@@ src/average_pool_3d_stream.sv @@
// Top level of the streaming 3D average pool: front end, queue, back end.
// Uses avp3_pkg, avp3_front, avp3_fifo and avp3_back.
//
//  Channel   Handshake               Payload
//  cfg       cfg_valid / cfg_ready   cfg_index, cfg_data
//  in        in_valid / in_ready     sample, volume_start
//  out       out_valid / out_ready   mean_value, out_x, out_y, out_z, channel, last
//
// A sample is taken every cycle while no counter rebuild is running, no configuration
// write is offered and the four-entry queue has room; samples outside whole windows
// leave no trace beyond the position counters. Each sum update in the back end is a
// RAM read, an add and a write back. A finished window occupies the divider until
// out_ready takes its mean, and the next window can start once the divider is idle
// again; the back end stalls only when a second window finishes meanwhile.
// After a configuration write the window counters are rebuilt from the position with
// in_ready low. Reset needs no clearing pass.
module average_pool_3d_stream #(
	parameter int MAX_SIZE     = 256,
	parameter int MAX_WINDOW   = 8,
	parameter int MAX_CHANNELS = 16,
	parameter int SAMPLE_BITS  = 16
) (
	input  logic                            clk,
	input  logic                            arst_n,
	input  logic                            cfg_valid,
	output logic                            cfg_ready,
	input  logic [avp3_pkg::CFG_IDX_W-1:0]  cfg_index,
	input  logic [avp3_pkg::CFG_DATA_W-1:0] cfg_data,
	input  logic                            in_valid,
	output logic                            in_ready,
	input  logic [SAMPLE_BITS-1:0]          sample,
	input  logic                            volume_start,
	output logic                            out_valid,
	input  logic                            out_ready,
	output logic [SAMPLE_BITS-1:0]          mean_value,
	output logic [avp3_pkg::COORD_W-1:0]    out_x,
	output logic [avp3_pkg::COORD_W-1:0]    out_y,
	output logic [avp3_pkg::COORD_W-1:0]    out_z,
	output logic [avp3_pkg::CHAN_W-1:0]     channel,
	output logic                            last
);

	import avp3_pkg::*;

	localparam int POS_BITS = $clog2(MAX_SIZE);
	localparam int CHN_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int ADDR_W   = 2 * POS_BITS + CHN_BITS;
	localparam int VOL_W    = $clog2(MAX_WINDOW * MAX_WINDOW * MAX_WINDOW + 1);
	localparam int SUM_BITS = SAMPLE_BITS + $clog2(MAX_WINDOW * MAX_WINDOW * MAX_WINDOW);
	localparam int ENTRY_W  = SAMPLE_BITS + ADDR_W + CTL_W + TAG_W;

	logic                   q_push, q_full, q_pop, q_valid;
	logic [SAMPLE_BITS-1:0] e_sample, h_sample;
	logic [ADDR_W-1:0]      e_addr, h_addr;
	avp3_ctl_t              e_ctl, h_ctl;
	logic [TAG_W-1:0]       e_tag, h_tag;
	logic [ENTRY_W-1:0]     h_entry;
	logic [VOL_W-1:0]       vol;
	logic [TAG_W:0]         out_tag;

	avp3_front #(
		.MAX_SIZE     (MAX_SIZE),
		.MAX_WINDOW   (MAX_WINDOW),
		.MAX_CHANNELS (MAX_CHANNELS),
		.SAMPLE_BITS  (SAMPLE_BITS),
		.ADDR_W       (ADDR_W),
		.VOL_W        (VOL_W)
	) u_front (
		.clk          (clk),
		.arst_n       (arst_n),
		.cfg_valid    (cfg_valid),
		.cfg_ready    (cfg_ready),
		.cfg_index    (cfg_index),
		.cfg_data     (cfg_data),
		.in_valid     (in_valid),
		.in_ready     (in_ready),
		.sample       (sample),
		.volume_start (volume_start),
		.q_full       (q_full),
		.q_push       (q_push),
		.e_sample     (e_sample),
		.e_addr       (e_addr),
		.e_ctl        (e_ctl),
		.e_tag        (e_tag),
		.vol          (vol)
	);

	avp3_fifo #(
		.WIDTH (ENTRY_W),
		.DEPTH (4)
	) u_queue (
		.clk    (clk),
		.arst_n (arst_n),
		.push   (q_push),
		.wdata  ({e_sample, e_addr, e_ctl, e_tag}),
		.full   (q_full),
		.pop    (q_pop),
		.valid  (q_valid),
		.rdata  (h_entry)
	);

	assign {h_sample, h_addr, h_ctl, h_tag} = h_entry;

	avp3_back #(
		.SAMPLE_BITS (SAMPLE_BITS),
		.ADDR_W      (ADDR_W),
		.VOL_W       (VOL_W),
		.SUM_BITS    (SUM_BITS)
	) u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.q_valid    (q_valid),
		.q_pop      (q_pop),
		.q_sample   (h_sample),
		.q_addr     (h_addr),
		.q_ctl      (h_ctl),
		.q_tag      (h_tag),
		.vol        (vol),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.mean_value (mean_value),
		.out_tag    (out_tag)
	);

	assign {out_x, out_y, out_z, channel, last} = out_tag;

	// A configuration write starts the counter rebuild
	assert property (@(posedge clk) disable iff (!arst_n) cfg_valid |=> !in_ready)
		else $error("input taken right after a configuration write");

	// The front end never writes into a full queue
	assert property (@(posedge clk) disable iff (!arst_n) q_push |-> !q_full)
		else $error("queue overflow");

	// A mean that was just taken cannot be followed by another in the next cycle
	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid && out_ready |=> !out_valid)
		else $error("divider produced results back to back");

endmodule

@@ src/avp3_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module avp3_ram #(
	parameter int WIDTH = 25,
	parameter int DEPTH = 1024
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] waddr,
	input  logic [WIDTH-1:0]         wdata,
	input  logic                     re,
	input  logic [$clog2(DEPTH)-1:0] raddr,
	output logic [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	// Write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[waddr] <= wdata;
		end
	end

	// Read port, old data on a same-address collision
	always_ff @(posedge clk) begin
		if (re) begin
			rdata <= mem_q[raddr];
		end
	end

endmodule

@@ src/avp3_fifo.sv @@
// Short first-word-fall-through queue between the front and back ends.
// No dependencies.
module avp3_fifo #(
	parameter int WIDTH = 64,
	parameter int DEPTH = 4
) (
	input  logic             clk,
	input  logic             arst_n,
	input  logic             push,
	input  logic [WIDTH-1:0] wdata,
	output logic             full,
	input  logic             pop,
	output logic             valid,
	output logic [WIDTH-1:0] rdata
);

	localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
	localparam int CNT_W = $clog2(DEPTH + 1);

	logic [WIDTH-1:0] slot_q [DEPTH];
	logic [PTR_W-1:0] wr_q;
	logic [PTR_W-1:0] rd_q;
	logic [CNT_W-1:0] count_q;

	assign full  = (32'(count_q) == DEPTH);
	assign valid = (count_q != '0);
	assign rdata = slot_q[rd_q];

	// Advance pointers and occupancy
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_q    <= '0;
			rd_q    <= '0;
			count_q <= '0;
		end else begin
			if (push) begin
				wr_q <= (32'(wr_q) == DEPTH - 1) ? '0 : wr_q + 1'b1;
			end
			if (pop) begin
				rd_q <= (32'(rd_q) == DEPTH - 1) ? '0 : rd_q + 1'b1;
			end
			if (push && !pop) begin
				count_q <= count_q + 1'b1;
			end else if (pop && !push) begin
				count_q <= count_q - 1'b1;
			end
		end
	end

	// Store entries
	always_ff @(posedge clk) begin
		if (push) begin
			slot_q[wr_q] <= wdata;
		end
	end

endmodule

@@ src/avp3_div.sv @@
// Sequential signed-by-unsigned divider, one quotient bit per cycle,
// truncating toward zero. Uses avp3_pkg for the state type.
module avp3_div #(
	parameter int SUM_BITS = 25,
	parameter int VOL_W    = 10,
	parameter int OUT_W    = 16,
	parameter int TAG_LEN  = 29
) (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                start,
	output logic                idle,
	input  logic [SUM_BITS-1:0] dividend,
	input  logic [VOL_W-1:0]    divisor,
	input  logic [TAG_LEN-1:0]  tag_in,
	output logic                out_valid,
	input  logic                out_ready,
	output logic [OUT_W-1:0]    quotient,
	output logic [TAG_LEN-1:0]  tag_out
);

	import avp3_pkg::*;

	localparam int CNT_W = $clog2(SUM_BITS + 1);

	dv_state_t         state_q;
	dv_state_t         state_d;
	logic [CNT_W-1:0]  cnt_q;
	logic [VOL_W-1:0]  rem_q;
	logic [SUM_BITS-1:0] quo_q;
	logic [VOL_W-1:0]  den_q;
	logic              neg_q;
	logic [TAG_LEN-1:0] tag_q;
	logic [VOL_W:0]    trial;
	logic              fits;
	logic [SUM_BITS-1:0] signed_quo;

	// One restoring step
	assign trial = {rem_q, quo_q[SUM_BITS-1]};
	assign fits  = (trial >= {1'b0, den_q});

	assign idle       = (state_q == DV_IDLE);
	assign out_valid  = (state_q == DV_DONE);
	assign signed_quo = neg_q ? (~quo_q + 1'b1) : quo_q;
	assign quotient   = signed_quo[OUT_W-1:0];
	assign tag_out    = tag_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= DV_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// Next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			DV_IDLE: if (start) state_d = DV_RUN;
			DV_RUN:  if (32'(cnt_q) == SUM_BITS - 1) state_d = DV_DONE;
			DV_DONE: if (out_ready) state_d = DV_IDLE;
			default: state_d = DV_IDLE;
		endcase
	end

	// Load operands, then shift in one quotient bit a cycle
	always_ff @(posedge clk) begin
		if (state_q == DV_IDLE && start) begin
			neg_q <= dividend[SUM_BITS-1];
			quo_q <= dividend[SUM_BITS-1] ? (~dividend + 1'b1) : dividend;
			rem_q <= '0;
			den_q <= divisor;
			cnt_q <= '0;
			tag_q <= tag_in;
		end else if (state_q == DV_RUN) begin
			rem_q <= fits ? VOL_W'(trial - {1'b0, den_q}) : trial[VOL_W-1:0];
			quo_q <= {quo_q[SUM_BITS-2:0], fits};
			cnt_q <= cnt_q + 1'b1;
		end
	end

endmodule

@@ src/avp3_front.sv @@
// Front end: configuration registers, position counters and sample
// classification. Uses avp3_pkg.
module avp3_front #(
	parameter int MAX_SIZE     = 256,
	parameter int MAX_WINDOW   = 8,
	parameter int MAX_CHANNELS = 16,
	parameter int SAMPLE_BITS  = 16,
	parameter int ADDR_W       = 20,
	parameter int VOL_W        = 10
) (
	input  logic                              clk,
	input  logic                              arst_n,
	input  logic                              cfg_valid,
	output logic                              cfg_ready,
	input  logic [avp3_pkg::CFG_IDX_W-1:0]    cfg_index,
	input  logic [avp3_pkg::CFG_DATA_W-1:0]   cfg_data,
	input  logic                              in_valid,
	output logic                              in_ready,
	input  logic [SAMPLE_BITS-1:0]            sample,
	input  logic                              volume_start,
	input  logic                              q_full,
	output logic                              q_push,
	output logic [SAMPLE_BITS-1:0]            e_sample,
	output logic [ADDR_W-1:0]                 e_addr,
	output avp3_pkg::avp3_ctl_t               e_ctl,
	output logic [avp3_pkg::TAG_W-1:0]        e_tag,
	output logic [VOL_W-1:0]                  vol
);

	import avp3_pkg::*;

	localparam int POS_BITS = $clog2(MAX_SIZE);
	localparam int SIZE_W   = $clog2(MAX_SIZE + 1);
	localparam int WIN_W    = $clog2(MAX_WINDOW + 1);
	localparam int CHN_BITS = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;
	localparam int CNT_W    = $clog2(MAX_CHANNELS + 1);
	localparam int WS_W     = $clog2(MAX_SIZE + 2 * MAX_WINDOW + 1);
	localparam int WXY_W    = $clog2(MAX_WINDOW * MAX_WINDOW + 1);

	function automatic logic [WIN_W-1:0] clamp_win(input logic [3:0] v);
		logic [WIN_W-1:0] r;
		if (v == '0) r = WIN_W'(1);
		else if (32'(v) > MAX_WINDOW) r = WIN_W'(MAX_WINDOW);
		else r = WIN_W'(v);
		return r;
	endfunction

	function automatic logic [SIZE_W-1:0] clamp_size(input logic [8:0] v);
		logic [SIZE_W-1:0] r;
		if (v == '0) r = SIZE_W'(1);
		else if (32'(v) > MAX_SIZE) r = SIZE_W'(MAX_SIZE);
		else r = SIZE_W'(v);
		return r;
	endfunction

	function automatic logic [CNT_W-1:0] clamp_chan(input logic [4:0] v);
		logic [CNT_W-1:0] r;
		if (v == '0) r = CNT_W'(1);
		else if (32'(v) > MAX_CHANNELS) r = CNT_W'(MAX_CHANNELS);
		else r = CNT_W'(v);
		return r;
	endfunction

	fe_state_t state_q;
	fe_state_t state_d;

	logic [WIN_W-1:0]  wx_q, wy_q, wz_q;
	logic [SIZE_W-1:0] sx_q, sy_q, sz_q;
	logic [CNT_W-1:0]  cc_q;
	logic [WXY_W-1:0]  wxy_q;
	logic [VOL_W-1:0]  vol_q;

	// Position: channel, absolute, in-window, window index, window start
	logic [CHN_BITS-1:0] pc_q;
	logic [POS_BITS-1:0] px_q, py_q, pz_q;
	logic [POS_BITS-1:0] lx_q, ly_q, lz_q;
	logic [POS_BITS-1:0] cx_q, cy_q, cz_q;
	logic [WS_W-1:0]     wsx_q, wsy_q, wsz_q;

	logic [CHN_BITS-1:0] cur_c, nxt_c;
	logic [POS_BITS-1:0] cur_px, cur_py, cur_pz, nxt_px, nxt_py, nxt_pz;
	logic [POS_BITS-1:0] cur_lx, cur_ly, cur_lz, nxt_lx, nxt_ly, nxt_lz;
	logic [POS_BITS-1:0] cur_cx, cur_cy, cur_cz, nxt_cx, nxt_cy, nxt_cz;
	logic [WS_W-1:0]     cur_wsx, cur_wsy, cur_wsz, nxt_wsx, nxt_wsy, nxt_wsz;

	logic restart, in_whole, accept, sync_done;
	logic lastcol_x, lastcol_y, lastcol_z;

	assign cfg_ready = 1'b1;
	assign in_ready  = (state_q == FE_RUN) && !q_full && !cfg_valid;
	assign accept    = in_valid && in_ready;
	assign q_push    = accept && in_whole;
	assign vol       = vol_q;

	assign sync_done = (32'(lx_q) < 32'(wx_q)) && (32'(ly_q) < 32'(wy_q)) &&
		(32'(lz_q) < 32'(wz_q));

	// Configuration registers and window volume
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wx_q  <= WIN_W'(2);
			wy_q  <= WIN_W'(2);
			wz_q  <= WIN_W'(2);
			sx_q  <= SIZE_W'(8);
			sy_q  <= SIZE_W'(8);
			sz_q  <= SIZE_W'(8);
			cc_q  <= CNT_W'(1);
			wxy_q <= WXY_W'(4);
			vol_q <= VOL_W'(8);
		end else begin
			if (cfg_valid) begin
				unique case (cfg_index)
					CFG_WINDOW_X: wx_q <= clamp_win(cfg_data[3:0]);
					CFG_WINDOW_Y: wy_q <= clamp_win(cfg_data[3:0]);
					CFG_WINDOW_Z: wz_q <= clamp_win(cfg_data[3:0]);
					CFG_SIZE_X:   sx_q <= clamp_size(cfg_data);
					CFG_SIZE_Y:   sy_q <= clamp_size(cfg_data);
					CFG_SIZE_Z:   sz_q <= clamp_size(cfg_data);
					CFG_CHANNELS: cc_q <= clamp_chan(cfg_data[4:0]);
					default: ;
				endcase
			end
			wxy_q <= WXY_W'(wx_q * wy_q);
			vol_q <= VOL_W'(wxy_q * wz_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= FE_RUN;
		end else begin
			state_q <= state_d;
		end
	end

	// Resynchronise window counters after a configuration write
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			FE_RUN:  if (cfg_valid) state_d = FE_SYNC;
			FE_SYNC: if (!cfg_valid && sync_done) state_d = FE_RUN;
			default: state_d = FE_RUN;
		endcase
	end

	// Classify the current sample and work out the next position
	always_comb begin
		restart = volume_start || (32'(pc_q) >= 32'(cc_q)) ||
			(32'(px_q) >= 32'(sx_q)) || (32'(py_q) >= 32'(sy_q)) ||
			(32'(pz_q) >= 32'(sz_q));
		if (restart) begin
			cur_c  = '0;
			cur_px = '0; cur_py = '0; cur_pz = '0;
			cur_lx = '0; cur_ly = '0; cur_lz = '0;
			cur_cx = '0; cur_cy = '0; cur_cz = '0;
			cur_wsx = '0; cur_wsy = '0; cur_wsz = '0;
		end else begin
			cur_c  = pc_q;
			cur_px = px_q; cur_py = py_q; cur_pz = pz_q;
			cur_lx = lx_q; cur_ly = ly_q; cur_lz = lz_q;
			cur_cx = cx_q; cur_cy = cy_q; cur_cz = cz_q;
			cur_wsx = wsx_q; cur_wsy = wsy_q; cur_wsz = wsz_q;
		end

		in_whole = (32'(cur_wsx) + 32'(wx_q) <= 32'(sx_q)) &&
			(32'(cur_wsy) + 32'(wy_q) <= 32'(sy_q)) &&
			(32'(cur_wsz) + 32'(wz_q) <= 32'(sz_q));
		lastcol_x = (32'(cur_wsx) + 2 * 32'(wx_q) > 32'(sx_q));
		lastcol_y = (32'(cur_wsy) + 2 * 32'(wy_q) > 32'(sy_q));
		lastcol_z = (32'(cur_wsz) + 2 * 32'(wz_q) > 32'(sz_q));

		e_ctl.first = (cur_lx == '0) && (cur_ly == '0) && (cur_lz == '0);
		e_ctl.done  = (32'(cur_lx) == 32'(wx_q) - 1) &&
			(32'(cur_ly) == 32'(wy_q) - 1) && (32'(cur_lz) == 32'(wz_q) - 1);
		e_ctl.last  = e_ctl.done && lastcol_x && lastcol_y && lastcol_z &&
			(32'(cur_c) == 32'(cc_q) - 1);

		// Advance channel, then x, y and z with their window counters
		nxt_c  = cur_c;
		nxt_px = cur_px; nxt_py = cur_py; nxt_pz = cur_pz;
		nxt_lx = cur_lx; nxt_ly = cur_ly; nxt_lz = cur_lz;
		nxt_cx = cur_cx; nxt_cy = cur_cy; nxt_cz = cur_cz;
		nxt_wsx = cur_wsx; nxt_wsy = cur_wsy; nxt_wsz = cur_wsz;
		if (32'(cur_c) + 1 >= 32'(cc_q)) begin
			nxt_c = '0;
			if (32'(cur_px) + 1 >= 32'(sx_q)) begin
				nxt_px = '0; nxt_lx = '0; nxt_cx = '0; nxt_wsx = '0;
				if (32'(cur_py) + 1 >= 32'(sy_q)) begin
					nxt_py = '0; nxt_ly = '0; nxt_cy = '0; nxt_wsy = '0;
					if (32'(cur_pz) + 1 >= 32'(sz_q)) begin
						nxt_pz = '0; nxt_lz = '0; nxt_cz = '0; nxt_wsz = '0;
					end else begin
						nxt_pz = cur_pz + 1'b1;
						if (32'(cur_lz) + 1 == 32'(wz_q)) begin
							nxt_lz  = '0;
							nxt_cz  = cur_cz + 1'b1;
							nxt_wsz = cur_wsz + WS_W'(wz_q);
						end else begin
							nxt_lz = cur_lz + 1'b1;
						end
					end
				end else begin
					nxt_py = cur_py + 1'b1;
					if (32'(cur_ly) + 1 == 32'(wy_q)) begin
						nxt_ly  = '0;
						nxt_cy  = cur_cy + 1'b1;
						nxt_wsy = cur_wsy + WS_W'(wy_q);
					end else begin
						nxt_ly = cur_ly + 1'b1;
					end
				end
			end else begin
				nxt_px = cur_px + 1'b1;
				if (32'(cur_lx) + 1 == 32'(wx_q)) begin
					nxt_lx  = '0;
					nxt_cx  = cur_cx + 1'b1;
					nxt_wsx = cur_wsx + WS_W'(wx_q);
				end else begin
					nxt_lx = cur_lx + 1'b1;
				end
			end
		end else begin
			nxt_c = cur_c + 1'b1;
		end
	end

	// Queue entry
	assign e_sample = sample;
	assign e_addr   = ADDR_W'({cur_cy, cur_cx, cur_c});
	assign e_tag    = {COORD_W'(cur_cx), COORD_W'(cur_cy), COORD_W'(cur_cz), CHAN_W'(cur_c)};

	// Position counters: reload on configuration, step during resync, advance on samples
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			pc_q <= '0;
			px_q <= '0; py_q <= '0; pz_q <= '0;
			lx_q <= '0; ly_q <= '0; lz_q <= '0;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			wsx_q <= '0; wsy_q <= '0; wsz_q <= '0;
		end else if (cfg_valid) begin
			lx_q <= px_q; ly_q <= py_q; lz_q <= pz_q;
			cx_q <= '0; cy_q <= '0; cz_q <= '0;
			wsx_q <= '0; wsy_q <= '0; wsz_q <= '0;
		end else if (state_q == FE_SYNC) begin
			if (32'(lx_q) >= 32'(wx_q)) begin
				lx_q  <= lx_q - POS_BITS'(wx_q);
				cx_q  <= cx_q + 1'b1;
				wsx_q <= wsx_q + WS_W'(wx_q);
			end
			if (32'(ly_q) >= 32'(wy_q)) begin
				ly_q  <= ly_q - POS_BITS'(wy_q);
				cy_q  <= cy_q + 1'b1;
				wsy_q <= wsy_q + WS_W'(wy_q);
			end
			if (32'(lz_q) >= 32'(wz_q)) begin
				lz_q  <= lz_q - POS_BITS'(wz_q);
				cz_q  <= cz_q + 1'b1;
				wsz_q <= wsz_q + WS_W'(wz_q);
			end
		end else if (accept) begin
			pc_q <= nxt_c;
			px_q <= nxt_px; py_q <= nxt_py; pz_q <= nxt_pz;
			lx_q <= nxt_lx; ly_q <= nxt_ly; lz_q <= nxt_lz;
			cx_q <= nxt_cx; cy_q <= nxt_cy; cz_q <= nxt_cz;
			wsx_q <= nxt_wsx; wsy_q <= nxt_wsy; wsz_q <= nxt_wsz;
		end
	end

endmodule

@@ src/avp3_back.sv @@
// Back end: read-modify-write of window sums in RAM and hand-off of
// finished windows to the divider. Uses avp3_pkg, avp3_ram, avp3_div.
module avp3_back #(
	parameter int SAMPLE_BITS = 16,
	parameter int ADDR_W      = 20,
	parameter int VOL_W       = 10,
	parameter int SUM_BITS    = 25
) (
	input  logic                          clk,
	input  logic                          arst_n,
	input  logic                          q_valid,
	output logic                          q_pop,
	input  logic [SAMPLE_BITS-1:0]        q_sample,
	input  logic [ADDR_W-1:0]             q_addr,
	input  avp3_pkg::avp3_ctl_t           q_ctl,
	input  logic [avp3_pkg::TAG_W-1:0]    q_tag,
	input  logic [VOL_W-1:0]              vol,
	output logic                          out_valid,
	input  logic                          out_ready,
	output logic [SAMPLE_BITS-1:0]        mean_value,
	output logic [avp3_pkg::TAG_W:0]      out_tag
);

	import avp3_pkg::*;

	logic                   s1_valid_q;
	logic [SAMPLE_BITS-1:0] sample_s1;
	logic [ADDR_W-1:0]      addr_s1;
	avp3_ctl_t              ctl_s1;
	logic [TAG_W-1:0]       tag_s1;
	logic                   fwd_s1;
	logic [SUM_BITS-1:0]    fwd_sum_s1;
	logic [SUM_BITS-1:0]    rdata;
	logic [SUM_BITS-1:0]    base;
	logic [SUM_BITS-1:0]    sum;
	logic                   go;
	logic                   div_idle;

	// Accumulate, taking the previous write when it hit the same sum
	assign base  = fwd_s1 ? fwd_sum_s1 : rdata;
	assign sum   = ctl_s1.first ? SUM_BITS'($signed(sample_s1))
		: base + SUM_BITS'($signed(sample_s1));
	assign go    = s1_valid_q && (!ctl_s1.done || div_idle);
	assign q_pop = q_valid && (!s1_valid_q || go);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			s1_valid_q <= 1'b0;
		end else if (q_pop) begin
			s1_valid_q <= 1'b1;
		end else if (go) begin
			s1_valid_q <= 1'b0;
		end
	end

	// Hold the transaction in the stage register
	always_ff @(posedge clk) begin
		if (q_pop) begin
			sample_s1  <= q_sample;
			addr_s1    <= q_addr;
			ctl_s1     <= q_ctl;
			tag_s1     <= q_tag;
			fwd_s1     <= go && (q_addr == addr_s1);
			fwd_sum_s1 <= sum;
		end
	end

	avp3_ram #(
		.WIDTH (SUM_BITS),
		.DEPTH (2 ** ADDR_W)
	) u_sums (
		.clk   (clk),
		.we    (go),
		.waddr (addr_s1),
		.wdata (sum),
		.re    (q_pop),
		.raddr (q_addr),
		.rdata (rdata)
	);

	avp3_div #(
		.SUM_BITS (SUM_BITS),
		.VOL_W    (VOL_W),
		.OUT_W    (SAMPLE_BITS),
		.TAG_LEN  (TAG_W + 1)
	) u_div (
		.clk       (clk),
		.arst_n    (arst_n),
		.start     (go && ctl_s1.done),
		.idle      (div_idle),
		.dividend  (sum),
		.divisor   (vol),
		.tag_in    ({tag_s1, ctl_s1.last}),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.quotient  (mean_value),
		.tag_out   (out_tag)
	);

endmodule
